FILE: hw/rtl/rat_pkg.sv
// Shared types, constants and codes for the resolved address TTL table.
package rat_pkg;

  localparam int NUM_SERVICES      = 16;
  localparam int SLOTS_PER_SERVICE = 8;
  localparam int TOTAL_SLOTS       = NUM_SERVICES * SLOTS_PER_SERVICE;
  localparam int SLOT_AW           = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1;
  localparam int IDX_W             = (SLOTS_PER_SERVICE > 1) ? $clog2(SLOTS_PER_SERVICE) : 1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_FIREWALL_ENABLED     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MASTER_MODE          = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPIRED_HOLD_SECONDS = 2'd2;

  localparam logic        FIREWALL_ENABLED_RST     = 1'b1;
  localparam logic        MASTER_MODE_RST          = 1'b0;
  localparam logic [31:0] EXPIRED_HOLD_SECONDS_RST = 32'd3600;

  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_DELETE = 2'd1;
  localparam logic [1:0] KIND_FULL   = 2'd2;

  typedef struct packed {
    logic        op;
    logic [3:0]  service_index;
    logic [31:0] ip_address;
    logic [31:0] ttl_seconds;
    logic [31:0] now_seconds;
  } req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] rule_address;
    logic [3:0]  rule_service;
    logic        also_forward;
    logic        last;
  } rsp_t;

  typedef struct packed {
    logic [31:0] address;
    logic [31:0] ttl;
    logic [31:0] updated_at;
    logic [31:0] expired_at;
  } slot_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH_EV,
    ST_ADD,
    ST_SWP_RD,
    ST_SWP_EV,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    ALU_EQ,
    ALU_GE,
    ALU_GT
  } alu_op_t;

  typedef struct packed {
    logic start;
    logic match_hit;
    logic last_idx;
    logic slot_live;
    logic slot_exp;
    logic cond_hit;
    logic out_free;
  } stat_t;

  typedef struct packed {
    logic busy;
    logic srch_init;
    logic search;
    logic srch_eval;
    logic idx_clr;
    logic idx_inc;
    logic add_do;
    logic mark_do;
    logic free_do;
    logic finish_do;
  } ctrl_t;

endpackage

FILE: hw/rtl/rat_ram.sv
// Generic single write port RAM with one registered read port.
module rat_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: hw/rtl/rat_alu.sv
// Shared subtract and compare unit for address match, expiry and hold tests.
module rat_alu
  import rat_pkg::*;
(
  input  alu_op_t     op,
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic [31:0] c,
  output logic        hit
);

  logic [31:0] diff;

  assign diff = a - b;

  always_comb begin
    case (op)
      ALU_EQ:  hit = (diff == 32'd0);
      ALU_GE:  hit = (diff >= c);
      ALU_GT:  hit = (diff > c);
      default: hit = 1'b0;
    endcase
  end

endmodule

FILE: hw/rtl/rat_fsm.sv
// Sequencer that walks one service's slots through search, add and sweep.
module rat_fsm
  import rat_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  stat_t stat,
  output ctrl_t ctrl
);

  state_t state;
  state_t state_next;
  logic   free_need;

  assign free_need = stat.slot_live && stat.slot_exp && stat.cond_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (stat.start) begin
          state_next = ST_SRCH_RD;
        end
      end
      ST_SRCH_RD: state_next = ST_SRCH_EV;
      ST_SRCH_EV: begin
        if (stat.match_hit || stat.last_idx) begin
          state_next = ST_ADD;
        end else begin
          state_next = ST_SRCH_RD;
        end
      end
      ST_ADD:    state_next = ST_SWP_RD;
      ST_SWP_RD: state_next = ST_SWP_EV;
      ST_SWP_EV: begin
        if (!(free_need && !stat.out_free)) begin
          state_next = stat.last_idx ? ST_FINISH : ST_SWP_RD;
        end
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    ctrl.busy = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        ctrl.srch_init = 1'b1;
        ctrl.idx_clr   = 1'b1;
      end
      ST_SRCH_EV: begin
        ctrl.search    = 1'b1;
        ctrl.srch_eval = 1'b1;
        ctrl.idx_inc   = !(stat.match_hit || stat.last_idx);
      end
      ST_ADD: begin
        ctrl.add_do  = 1'b1;
        ctrl.idx_clr = 1'b1;
      end
      ST_SWP_EV: begin
        ctrl.mark_do = stat.slot_live && !stat.slot_exp && stat.cond_hit;
        ctrl.free_do = free_need && stat.out_free;
        ctrl.idx_inc = !stat.last_idx && !(free_need && !stat.out_free);
      end
      ST_FINISH: begin
        ctrl.finish_do = stat.out_free;
      end
      default: ctrl.busy = (state != ST_IDLE);
    endcase
  end

endmodule

FILE: hw/rtl/resolved_address_ttl_table_core.sv
// Top level of the resolved address TTL table: slot flags, slot RAM, shared unit, output.
// A record request for a valid service visits that service's slots one at a time
// through the single registered read port of the slot RAM, with a read state and an
// evaluate state per slot: a search pass (stops early on an address match), an add
// step that writes the added slot, a sweep pass and a finish step that hands over the
// final result. The sweep and finish steps wait while the result side holds stall. The
// add or table-full result comes first, then delete results in slot order; last marks
// the final one. Clear, disabled and out-of-range requests are accepted only while idle
// and give no result. req_stall is high while a record request is in progress.
module resolved_address_ttl_table_core
  import rat_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  req_t                  req_data,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output rsp_t                  rsp_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic        firewall_enabled;
  logic        master_mode;
  logic [31:0] expired_hold_seconds;

  logic [TOTAL_SLOTS-1:0] use_flags;
  logic [TOTAL_SLOTS-1:0] exp_flags;

  logic [3:0]         cur_svc;
  logic [31:0]        cur_addr;
  logic [31:0]        cur_ttl;
  logic [31:0]        cur_now;
  logic [SLOT_AW-1:0] base;
  logic [IDX_W-1:0]   idx;
  logic [IDX_W-1:0]   pick;
  logic               match_found;
  logic               free_found;

  rsp_t pend;
  logic pend_valid;
  rsp_t out_data;
  logic out_valid;

  logic [SLOT_AW-1:0] slot_sel;
  logic [SLOT_AW-1:0] pick_sel;
  logic               accept;
  logic               svc_ok;
  logic               use_cur;
  logic               exp_cur;

  slot_word_t rd_word;
  slot_word_t wr_word;
  logic       ram_we;
  logic [SLOT_AW-1:0] wr_sel;

  alu_op_t     alu_op;
  logic [31:0] alu_a;
  logic [31:0] alu_b;
  logic [31:0] alu_c;
  logic        alu_hit;

  stat_t stat;
  ctrl_t ctrl;

  assign accept    = req_valid && !req_stall;
  assign req_stall = ctrl.busy;
  assign svc_ok    = (32'(req_data.service_index) < 32'(NUM_SERVICES));
  assign slot_sel  = base + SLOT_AW'(idx);
  assign pick_sel  = base + SLOT_AW'(pick);
  assign use_cur   = use_flags[slot_sel];
  assign exp_cur   = exp_flags[slot_sel];

  assign rsp_valid = out_valid;
  assign rsp_data  = out_data;

  assign stat.start     = accept && firewall_enabled && (req_data.op == OP_RECORD) && svc_ok;
  assign stat.match_hit = use_cur && alu_hit;
  assign stat.last_idx  = (idx == IDX_W'(SLOTS_PER_SERVICE - 1));
  assign stat.slot_live = use_cur;
  assign stat.slot_exp  = exp_cur;
  assign stat.cond_hit  = alu_hit;
  assign stat.out_free  = !out_valid || !rsp_stall;

  rat_fsm u_fsm (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  always_comb begin
    if (ctrl.search) begin
      alu_op = ALU_EQ;
      alu_a  = rd_word.address;
      alu_b  = cur_addr;
      alu_c  = 32'd0;
    end else if (exp_cur) begin
      alu_op = ALU_GT;
      alu_a  = cur_now;
      alu_b  = rd_word.expired_at;
      alu_c  = expired_hold_seconds;
    end else begin
      alu_op = ALU_GE;
      alu_a  = cur_now;
      alu_b  = rd_word.updated_at;
      alu_c  = rd_word.ttl;
    end
  end

  rat_alu u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .c   (alu_c),
    .hit (alu_hit)
  );

  always_comb begin
    ram_we = 1'b0;
    wr_sel = slot_sel;
    wr_word = rd_word;
    if (ctrl.add_do) begin
      ram_we = match_found || free_found;
      wr_sel = pick_sel;
      wr_word.address    = cur_addr;
      wr_word.ttl        = cur_ttl;
      wr_word.updated_at = cur_now;
      wr_word.expired_at = 32'd0;
    end else if (ctrl.mark_do) begin
      ram_we = 1'b1;
      wr_word.expired_at = cur_now;
    end
  end

  rat_ram #(
    .WIDTH ($bits(slot_word_t)),
    .DEPTH (TOTAL_SLOTS)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (wr_sel),
    .wr_data (wr_word),
    .rd_addr (slot_sel),
    .rd_data (rd_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      firewall_enabled     <= FIREWALL_ENABLED_RST;
      master_mode          <= MASTER_MODE_RST;
      expired_hold_seconds <= EXPIRED_HOLD_SECONDS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FIREWALL_ENABLED:     firewall_enabled     <= cfg_data[0];
        CFG_MASTER_MODE:          master_mode          <= cfg_data[0];
        CFG_EXPIRED_HOLD_SECONDS: expired_hold_seconds <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      use_flags <= '0;
      exp_flags <= '0;
    end else if (accept && firewall_enabled && (req_data.op == OP_CLEAR)) begin
      use_flags <= '0;
      exp_flags <= '0;
    end else if (ctrl.add_do) begin
      if (match_found || free_found) begin
        use_flags[pick_sel] <= 1'b1;
        exp_flags[pick_sel] <= 1'b0;
      end
    end else if (ctrl.mark_do) begin
      exp_flags[slot_sel] <= 1'b1;
    end else if (ctrl.free_do) begin
      use_flags[slot_sel] <= 1'b0;
      exp_flags[slot_sel] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_svc  <= req_data.service_index;
      cur_addr <= req_data.ip_address;
      cur_ttl  <= req_data.ttl_seconds;
      cur_now  <= req_data.now_seconds;
      base     <= SLOT_AW'(req_data.service_index) * SLOT_AW'(SLOTS_PER_SERVICE);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx         <= '0;
      pick        <= '0;
      match_found <= 1'b0;
      free_found  <= 1'b0;
    end else begin
      if (ctrl.idx_clr) begin
        idx <= '0;
      end else if (ctrl.idx_inc) begin
        idx <= idx + IDX_W'(1);
      end
      if (ctrl.srch_init) begin
        match_found <= 1'b0;
        free_found  <= 1'b0;
      end else if (ctrl.srch_eval) begin
        if (stat.match_hit) begin
          match_found <= 1'b1;
          pick        <= idx;
        end else if (!use_cur && !free_found) begin
          free_found <= 1'b1;
          pick       <= idx;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (ctrl.add_do) begin
      pend_valid <= 1'b1;
    end else if (ctrl.finish_do) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.add_do) begin
      pend.rule_service <= cur_svc;
      pend.last         <= 1'b0;
      if (match_found || free_found) begin
        pend.kind         <= KIND_ADD;
        pend.rule_address <= cur_addr;
        pend.also_forward <= master_mode;
      end else begin
        pend.kind         <= KIND_FULL;
        pend.rule_address <= 32'd0;
        pend.also_forward <= 1'b0;
      end
    end else if (ctrl.free_do) begin
      pend.kind         <= KIND_DELETE;
      pend.rule_address <= rd_word.address;
      pend.rule_service <= cur_svc;
      pend.also_forward <= master_mode;
      pend.last         <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.free_do || ctrl.finish_do) begin
      out_valid <= 1'b1;
    end else if (out_valid && !rsp_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.free_do || ctrl.finish_do) begin
      out_data <= '{kind:         pend.kind,
                    rule_address: pend.rule_address,
                    rule_service: pend.rule_service,
                    also_forward: pend.also_forward,
                    last:         ctrl.finish_do};
    end
  end

`ifndef ASSERT_OFF
  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    !req_stall |-> !pend_valid)
    else $error("pending result left when idle");

  a_add_sets_pend: assert property (@(posedge clk) disable iff (rst)
    ctrl.add_do |=> pend_valid)
    else $error("add step did not queue a result");

  a_expired_live: assert property (@(posedge clk) disable iff (rst)
    (exp_flags & ~use_flags) == '0)
    else $error("expired flag on a free slot");

  a_full_fields: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_data.kind == KIND_FULL) |->
      (rsp_data.rule_address == 32'd0 && !rsp_data.also_forward))
    else $error("table-full result carries address or forward flag");

  a_emit_needs_room: assert property (@(posedge clk) disable iff (rst)
    (ctrl.free_do || ctrl.finish_do) |-> (pend_valid && (!out_valid || !rsp_stall)))
    else $error("result emitted without room or pending entry");
`endif

endmodule
